/* src/pneumatic_cycle_sequencer_defines.svh */
// assertion macros used by the sequencer checker
`ifndef PNEUMATIC_CYCLE_SEQUENCER_DEFINES_SVH
`define PNEUMATIC_CYCLE_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define PCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/pcs_pkg.sv */
// types and constants of the pneumatic cycle sequencer
package pcs_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SENSE = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic [1:0] CYL_STAT_OFF   = 2'd0;
    localparam logic [1:0] CYL_STAT_ON    = 2'd1;
    localparam logic [1:0] CYL_STAT_FAULT = 2'd2;

    // cylinder indexes
    localparam logic [1:0] CYL_FEED   = 2'd0;
    localparam logic [1:0] CYL_STRIKE = 2'd1;
    localparam logic [1:0] CYL_CLAMP  = 2'd2;
    localparam logic [1:0] CYL_TOOL   = 2'd3;

    localparam logic [4:0] STEP_FIRST = 5'd1;
    localparam logic [4:0] STEP_LAST  = 5'd16;
    localparam logic [4:0] STEP_IDLE  = 5'd20;

    localparam logic [15:0] FIRST_DELAY   = 16'd40;
    localparam logic [15:0] DELAY_RESET   = 16'd20;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [63:0] LIMITS_RESET  = 64'h0064_0064_0064_0064;

    // register indexes
    localparam logic [2:0] REG_FEED_TO_STRIKE  = 3'd0;
    localparam logic [2:0] REG_STRIKE_TO_CLAMP = 3'd1;
    localparam logic [2:0] REG_STRIKE_OFF      = 3'd2;
    localparam logic [2:0] REG_FEED_OFF        = 3'd3;
    localparam logic [2:0] REG_TOOL_ON         = 3'd4;
    localparam logic [2:0] REG_TOOL_OFF        = 3'd5;
    localparam logic [2:0] REG_CLAMP_OFF       = 3'd6;
    localparam logic [2:0] REG_FAULT_LIMITS    = 3'd7;

    typedef struct packed {
        logic [15:0]       delay_feed_to_strike;
        logic [15:0]       delay_strike_to_clamp;
        logic [15:0]       delay_strike_off;
        logic [15:0]       delay_feed_off;
        logic [15:0]       delay_tool_on;
        logic [15:0]       delay_tool_off;
        logic [15:0]       delay_clamp_off;
        logic [3:0][15:0]  fault_limits;
    } pcs_cfg_t;

    typedef struct packed {
        logic [4:0]       step;
        logic [15:0]      delay_ticks;
        logic [15:0]      fault_ticks;
        logic [3:0]       valve;
        logic [3:0][1:0]  cyl_state;
        logic             alarm;
        logic [15:0]      pieces;
    } pcs_state_t;

endpackage

/* src/pcs_step.sv */
// next-state logic of the sequencer for one request
module pcs_step
    import pcs_pkg::*;
(
    input  pcs_state_t  cur,
    input  pcs_cfg_t    cfg,
    input  logic [1:0]  op,
    input  logic [7:0]  sensor_bits,
    output pcs_state_t  nxt,
    output logic        refresh
);

    logic        wait_en;
    logic        delay_en;
    logic        hit;
    logic        turn_on;
    logic [1:0]  cyl;
    logic [15:0] dly_lim;
    logic [15:0] fault_lim;

    // step table decode
    always_comb
    begin
        wait_en  = 1'b0;
        delay_en = 1'b0;
        hit      = 1'b0;
        turn_on  = 1'b0;
        cyl      = CYL_FEED;
        dly_lim  = '0;
        case (cur.step)
            5'd1:
            begin
                wait_en = 1'b1;
                hit     = sensor_bits[0] & sensor_bits[2] & sensor_bits[4] & sensor_bits[6];
                cyl     = CYL_CLAMP;
            end
            5'd2:
            begin
                delay_en = 1'b1;
                dly_lim  = FIRST_DELAY;
                cyl      = CYL_FEED;
                turn_on  = 1'b1;
            end
            5'd3:
            begin
                wait_en = 1'b1;
                hit     = sensor_bits[1];
                cyl     = CYL_FEED;
            end
            5'd4:
            begin
                delay_en = 1'b1;
                dly_lim  = cfg.delay_feed_to_strike;
                cyl      = CYL_STRIKE;
                turn_on  = 1'b1;
            end
            5'd5:
            begin
                wait_en = 1'b1;
                hit     = sensor_bits[3];
                cyl     = CYL_STRIKE;
            end
            5'd6:
            begin
                delay_en = 1'b1;
                dly_lim  = cfg.delay_strike_to_clamp;
                cyl      = CYL_CLAMP;
                turn_on  = 1'b1;
            end
            5'd7:
            begin
                wait_en = 1'b1;
                hit     = sensor_bits[5];
                cyl     = CYL_CLAMP;
            end
            5'd8:
            begin
                delay_en = 1'b1;
                dly_lim  = cfg.delay_strike_off;
                cyl      = CYL_STRIKE;
            end
            5'd9:
            begin
                wait_en = 1'b1;
                hit     = sensor_bits[2];
                cyl     = CYL_STRIKE;
            end
            5'd10:
            begin
                delay_en = 1'b1;
                dly_lim  = cfg.delay_feed_off;
                cyl      = CYL_FEED;
            end
            5'd11:
            begin
                wait_en = 1'b1;
                hit     = sensor_bits[0];
                cyl     = CYL_FEED;
            end
            5'd12:
            begin
                delay_en = 1'b1;
                dly_lim  = cfg.delay_tool_on;
                cyl      = CYL_TOOL;
                turn_on  = 1'b1;
            end
            5'd13:
            begin
                wait_en = 1'b1;
                hit     = sensor_bits[7];
                cyl     = CYL_TOOL;
            end
            5'd14:
            begin
                delay_en = 1'b1;
                dly_lim  = cfg.delay_tool_off;
                cyl      = CYL_TOOL;
            end
            5'd15:
            begin
                wait_en = 1'b1;
                hit     = sensor_bits[6];
                cyl     = CYL_TOOL;
            end
            5'd16:
            begin
                delay_en = 1'b1;
                dly_lim  = cfg.delay_clamp_off;
                cyl      = CYL_CLAMP;
            end
            default:
            begin
                wait_en  = 1'b0;
                delay_en = 1'b0;
            end
        endcase
    end

    assign fault_lim = cfg.fault_limits[cyl];

    always_comb
    begin
        nxt     = cur;
        refresh = 1'b0;
        case (op)
            OP_TICK:
            begin
                if (cur.delay_ticks != COUNT_MAX)
                    nxt.delay_ticks = cur.delay_ticks + 16'd1;
                if (cur.fault_ticks != COUNT_MAX)
                    nxt.fault_ticks = cur.fault_ticks + 16'd1;
            end
            OP_SENSE:
            begin
                if (wait_en)
                begin
                    if (hit)
                    begin
                        nxt.delay_ticks = '0;
                        nxt.step        = cur.step + 5'd1;
                    end
                    else if (cur.fault_ticks > fault_lim)
                    begin
                        nxt.alarm          = 1'b1;
                        nxt.cyl_state[cyl] = CYL_STAT_FAULT;
                        refresh            = 1'b1;
                    end
                end
                else if (delay_en && (cur.delay_ticks > dly_lim))
                begin
                    // valves are active low
                    nxt.valve[cyl]     = ~turn_on;
                    nxt.cyl_state[cyl] = turn_on ? CYL_STAT_ON : CYL_STAT_OFF;
                    nxt.fault_ticks    = '0;
                    refresh            = 1'b1;
                    if (cur.step == STEP_LAST)
                    begin
                        nxt.step   = STEP_FIRST;
                        nxt.pieces = cur.pieces + 16'd1;
                    end
                    else
                    begin
                        nxt.step = cur.step + 5'd1;
                    end
                end
            end
            OP_START:
            begin
                if (cur.step == STEP_IDLE)
                    nxt.step = STEP_FIRST;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

/* src/pneumatic_cycle_sequencer.sv */
// top level of the pneumatic cycle sequencer
// Sixteen-step machine-cycle sequencer for four pneumatic cylinders. Each request
// on the input stream (tick, sense or start in s_tuser, sensor bits in s_tdata)
// is worked off as soon as it is taken: the step logic updates the sequencer state
// and the new status is registered as one result on the output stream. A request
// is taken every cycle while the result register is empty or being drained, so
// the sustained rate is one request per cycle, and each result is presented in the
// cycle after its request is taken. Delay and fault-limit registers sit on a 64-bit
// APB port at byte address 8*index and should be written while the stream is idle.
module pneumatic_cycle_sequencer
    import pcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] sensor_bits
    input  logic [1:0]  s_tuser,    // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] valve_drive, [5:4] feed_status, [7:6] strike_status,
    // [9:8] clamp_status, [11:10] tool_status, [12] alarm_active,
    // [13] refresh_pulse, [29:14] pieces_done, [34:30] current_step, rest zero
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    pcs_cfg_t    cfg_reg;
    pcs_state_t  state_reg;
    pcs_state_t  state_next;
    logic        refresh_next;
    logic        m_tvalid_reg;
    logic [34:0] out_reg;
    logic        in_fire;
    logic        cfg_write;
    logic [2:0]  reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[5:3];
    assign cfg_write = psel && penable && pwrite && pready;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delay_feed_to_strike  <= DELAY_RESET;
            cfg_reg.delay_strike_to_clamp <= DELAY_RESET;
            cfg_reg.delay_strike_off      <= DELAY_RESET;
            cfg_reg.delay_feed_off        <= DELAY_RESET;
            cfg_reg.delay_tool_on         <= DELAY_RESET;
            cfg_reg.delay_tool_off        <= DELAY_RESET;
            cfg_reg.delay_clamp_off       <= DELAY_RESET;
            cfg_reg.fault_limits          <= LIMITS_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_FEED_TO_STRIKE:  cfg_reg.delay_feed_to_strike  <= pwdata[15:0];
                REG_STRIKE_TO_CLAMP: cfg_reg.delay_strike_to_clamp <= pwdata[15:0];
                REG_STRIKE_OFF:      cfg_reg.delay_strike_off      <= pwdata[15:0];
                REG_FEED_OFF:        cfg_reg.delay_feed_off        <= pwdata[15:0];
                REG_TOOL_ON:         cfg_reg.delay_tool_on         <= pwdata[15:0];
                REG_TOOL_OFF:        cfg_reg.delay_tool_off        <= pwdata[15:0];
                REG_CLAMP_OFF:       cfg_reg.delay_clamp_off       <= pwdata[15:0];
                REG_FAULT_LIMITS:    cfg_reg.fault_limits          <= pwdata;
                default:             cfg_reg.fault_limits          <= cfg_reg.fault_limits;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FEED_TO_STRIKE:  prdata = {48'd0, cfg_reg.delay_feed_to_strike};
            REG_STRIKE_TO_CLAMP: prdata = {48'd0, cfg_reg.delay_strike_to_clamp};
            REG_STRIKE_OFF:      prdata = {48'd0, cfg_reg.delay_strike_off};
            REG_FEED_OFF:        prdata = {48'd0, cfg_reg.delay_feed_off};
            REG_TOOL_ON:         prdata = {48'd0, cfg_reg.delay_tool_on};
            REG_TOOL_OFF:        prdata = {48'd0, cfg_reg.delay_tool_off};
            REG_CLAMP_OFF:       prdata = {48'd0, cfg_reg.delay_clamp_off};
            REG_FAULT_LIMITS:    prdata = cfg_reg.fault_limits;
            default:             prdata = '0;
        endcase
    end

    pcs_step u_step (
        .cur         (state_reg),
        .cfg         (cfg_reg),
        .op          (s_tuser),
        .sensor_bits (s_tdata),
        .nxt         (state_next),
        .refresh     (refresh_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.step        <= STEP_IDLE;
            state_reg.delay_ticks <= '0;
            state_reg.fault_ticks <= '0;
            state_reg.valve       <= 4'hF;
            state_reg.cyl_state   <= '0;
            state_reg.alarm       <= 1'b0;
            state_reg.pieces      <= '0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (s_tready)
            m_tvalid_reg <= s_tvalid;
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_reg <= {state_next.step, state_next.pieces, refresh_next,
                        state_next.alarm, state_next.cyl_state[3],
                        state_next.cyl_state[2], state_next.cyl_state[1],
                        state_next.cyl_state[0], state_next.valve};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_reg};

endmodule

/* src/pcs_checker.sv */
// port-level checker of the sequencer and its bind
`include "pneumatic_cycle_sequencer_defines.svh"

module pcs_checker
    import pcs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    logic [4:0] step_out;
    logic [3:0] valve_out;
    logic       valve_ok;

    assign step_out  = m_tdata[34:30];
    assign valve_out = m_tdata[3:0];

    // a status of on means the valve is energized, off means released
    assign valve_ok =
        !((m_tdata[5:4] == CYL_STAT_ON && valve_out[0]) ||
          (m_tdata[5:4] == CYL_STAT_OFF && !valve_out[0]) ||
          (m_tdata[7:6] == CYL_STAT_ON && valve_out[1]) ||
          (m_tdata[7:6] == CYL_STAT_OFF && !valve_out[1]) ||
          (m_tdata[9:8] == CYL_STAT_ON && valve_out[2]) ||
          (m_tdata[9:8] == CYL_STAT_OFF && !valve_out[2]) ||
          (m_tdata[11:10] == CYL_STAT_ON && valve_out[3]) ||
          (m_tdata[11:10] == CYL_STAT_OFF && !valve_out[3]));

    `PCS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
    `PCS_ASSERT_SAME(a_ready, !m_tvalid, s_tready, "input stalled with empty result register")
    `PCS_ASSERT_SAME(a_step, m_tvalid, (step_out != 5'd0 && step_out <= STEP_LAST) || step_out == STEP_IDLE, "illegal step reported")
    `PCS_ASSERT_NEXT(a_alarm, m_tvalid && m_tready && m_tdata[12], !m_tvalid || m_tdata[12], "alarm cleared without reset")
    `PCS_ASSERT_SAME(a_valve, m_tvalid, valve_ok, "valve drive disagrees with cylinder status")

endmodule

bind pneumatic_cycle_sequencer pcs_checker u_pcs_checker (.*);
